// ===== rtl/kfci_pkg.sv =====
// ----------------------------------------------------------------------------
// kfci_pkg
// Shared types, codes and helpers of the keyframe curve interpolator.
// ----------------------------------------------------------------------------
package kfci_pkg;

  // Table geometry.
  localparam int MAX_KEYFRAMES = 64;
  localparam int IDX_W         = $clog2(MAX_KEYFRAMES);
  localparam int CNT_W         = IDX_W + 1;

  // Input opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  // Curve modes.
  localparam logic [1:0] MODE_LIN = 2'd0;
  localparam logic [1:0] MODE_CUB = 2'd1;

  // Configuration register indexes.
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_MODE  = 1'b1;

  // One stored keyframe.
  typedef struct packed {
    logic [23:0]        pos;
    logic               has_pos;
    logic signed [15:0] amp;
    logic               has_amp;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  // Clamp a wide signed value to the Q1.15 range.
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] res;
    if (v > 22'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/kfci_ram.sv =====
// ----------------------------------------------------------------------------
// kfci_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module kfci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/keyframe_curve_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_top
// Keyframe table with linear and smoothstep curve evaluation.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready) carries one transaction per item:
//   clear the table, append a keyframe, or evaluate the curve at a time.
// - Output channel (out_valid/out_ready) returns exactly one transaction
//   per item: the curve value and a status code.
// - Configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   effect start offset (index 0) and the curve mode (index 1).
// - One item is worked on at a time; in_ready is high only while idle.
// - Clear, append and no-op items go from idle straight to the result state.
// - An evaluation scans the table one keyframe per cycle through the
//   memory read port and, when interpolation is needed, then runs the
//   datapath of the curve mode (18-step divider for linear, 16-step
//   divider and three multiplies for smoothstep).
// - The output holds one finished result; when the receiver stalls, the
//   next result waits inside the block and no new item is taken.
// - Synchronous reset empties the table count, clears the control registers and
//   drops any pending result; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator_top (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [23:0]        in_key_position,
  input  logic               in_key_has_position,
  input  logic signed [15:0] in_key_amplitude,
  input  logic               in_key_has_amplitude,
  input  logic [31:0]        in_query_time,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_curve_value,
  output logic [1:0]         out_status,
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_LMUL = 4'd3;
  localparam logic [3:0] S_LSET = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_LFIN = 4'd6;
  localparam logic [3:0] S_CU2  = 4'd7;
  localparam logic [3:0] S_CU3  = 4'd8;
  localparam logic [3:0] S_CS32 = 4'd9;
  localparam logic [3:0] S_CMUL = 4'd10;
  localparam logic [3:0] S_CFIN = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Control registers.
  logic [3:0]                 state_r;
  logic [kfci_pkg::CNT_W-1:0] count_r;
  logic [kfci_pkg::IDX_W-1:0] scan_r;
  logic                       prev_v_r;
  logic                       out_valid_r;
  logic [23:0]                start_r;
  logic [1:0]                 mode_r;

  // Datapath registers.
  logic [23:0]        p0_r;
  logic [23:0]        p1_r;
  logic signed [15:0] f0_r;
  logic signed [15:0] f1_r;
  logic signed [34:0] r_r;
  logic signed [34:0] d_r;
  logic signed [34:0] h_r;
  logic signed [51:0] prod_r;
  logic [34:0]        rem_r;
  logic [34:0]        den_r;
  logic [17:0]        lo_r;
  logic [17:0]        q_r;
  logic [4:0]         cnt_r;
  logic               neg_r;
  logic [31:0]        u2_r;
  logic [47:0]        u3_r;
  logic [33:0]        s32_r;
  logic signed [15:0] res_val_r;
  logic [1:0]         res_st_r;
  logic signed [15:0] out_val_r;
  logic [1:0]         out_st_r;

  // Memory interface.
  logic                       ram_wen;
  logic [kfci_pkg::IDX_W-1:0] ram_raddr;
  kfci_pkg::key_entry_t       ram_wdata;
  kfci_pkg::key_entry_t       ram_rdata;
  logic [kfci_pkg::ENTRY_W-1:0] ram_rbits;

  logic in_fire;
  logic out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_curve_value = out_val_r;
  assign out_status      = out_st_r;

  // A finished result moves to the output register once that is free.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Append writes at the current fill level; the scan reads one ahead.
  assign ram_wen   = in_fire && (in_opcode == kfci_pkg::OP_APPEND) &&
                     (count_r < kfci_pkg::CNT_W'(kfci_pkg::MAX_KEYFRAMES));
  assign ram_wdata = '{pos: in_key_position, has_pos: in_key_has_position,
                       amp: in_key_amplitude, has_amp: in_key_has_amplitude};
  assign ram_raddr = (state_r == S_SCAN) ? scan_r + 1'b1 : '0;
  assign ram_rdata = kfci_pkg::key_entry_t'(ram_rbits);

  kfci_ram #(
    .WIDTH(kfci_pkg::ENTRY_W),
    .DEPTH(kfci_pkg::MAX_KEYFRAMES)
  ) u_table (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(count_r[kfci_pkg::IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

  // Scan compare: the entry is complete and lies strictly after the query.
  logic entry_complete;
  logic entry_after;
  logic scan_last;
  assign entry_complete = ram_rdata.has_pos && ram_rdata.has_amp;
  assign entry_after    = $signed({3'b000, ram_rdata.pos, 8'h00}) > r_r;
  assign scan_last      = ({1'b0, scan_r} + 1'b1) == count_r;

  // Segment geometry.
  logic signed [34:0] seg_h;
  logic signed [34:0] seg_d;
  logic signed [16:0] diff;
  assign seg_h = $signed({3'b000, p1_r, 8'h00}) - $signed({3'b000, p0_r, 8'h00});
  assign seg_d = r_r - $signed({3'b000, p0_r, 8'h00});
  assign diff  = $signed({f1_r[15], f1_r}) - $signed({f0_r[15], f0_r});

  // Shared multiplier for the linear product and the smoothstep blend.
  logic signed [34:0] mul_b;
  logic signed [51:0] mul_p;
  assign mul_b = (state_r == S_CMUL) ? $signed({1'b0, s32_r}) : d_r;
  assign mul_p = diff * mul_b;

  // Linear setup: rounded-floor numerator 2*prod + h, split into sign and size.
  logic signed [52:0] lin_n;
  logic [52:0]        lin_abs;
  assign lin_n   = $signed({prod_r, 1'b0}) + 53'(h_r);
  assign lin_abs = lin_n[52] ? 53'(-lin_n) : 53'(lin_n);

  // One restoring divider step.
  logic [34:0] div_t;
  logic        div_ge;
  assign div_t  = {rem_r[33:0], lo_r[17]};
  assign div_ge = div_t >= den_r;

  // Linear finish: floor of the signed quotient.
  logic [19:0]        lin_adj;
  logic signed [19:0] lin_q;
  logic signed [21:0] lin_v;
  assign lin_adj = {2'b00, q_r} + {19'd0, (rem_r != '0)};
  assign lin_q   = neg_r ? -$signed(lin_adj) : $signed({2'b00, q_r});
  assign lin_v   = $signed({{6{f0_r[15]}}, f0_r}) + $signed({{2{lin_q[19]}}, lin_q});

  // Smoothstep polynomial 3*u^2*2^16 - 2*u^3 and its Q0.32 rounding.
  logic [49:0] s48;
  logic [49:0] s48_rnd;
  assign s48     = ({2'b00, u2_r, 16'h0000} << 1) + {2'b00, u2_r, 16'h0000} -
                   ({2'b00, u3_r} << 1);
  assign s48_rnd = s48 + 50'd32768;

  // Cubic finish: round the blend by 2^32.
  logic signed [51:0] cub_r;
  logic signed [21:0] cub_v;
  assign cub_r = prod_r + $signed({20'd0, 1'b1, 31'd0});
  assign cub_v = $signed({{6{f0_r[15]}}, f0_r}) +
                 $signed({{2{cub_r[51]}}, cub_r[51:32]});

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      prev_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      mode_r      <= kfci_pkg::MODE_LIN;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kfci_pkg::CFG_START: start_r <= cfg_data;
          kfci_pkg::CFG_MODE:  mode_r  <= cfg_data[1:0];
          default: ;
        endcase
      end

      // Result register loads a finished result or drains toward the receiver.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_val_r <= '0;
            case (in_opcode)
              kfci_pkg::OP_CLEAR: begin
                count_r  <= '0;
                res_st_r <= kfci_pkg::ST_DONE;
                state_r  <= S_OUT;
              end
              kfci_pkg::OP_APPEND: begin
                if (ram_wen) begin
                  count_r  <= count_r + 1'b1;
                  res_st_r <= kfci_pkg::ST_DONE;
                end else begin
                  res_st_r <= kfci_pkg::ST_FULL;
                end
                state_r <= S_OUT;
              end
              kfci_pkg::OP_EVAL: begin
                res_st_r <= kfci_pkg::ST_EVAL;
                r_r      <= $signed({3'b000, in_query_time}) -
                            $signed({3'b000, start_r, 8'h00});
                scan_r   <= '0;
                prev_v_r <= 1'b0;
                state_r  <= (count_r != '0) ? S_SCAN : S_OUT;
              end
              default: begin
                res_st_r <= kfci_pkg::ST_DONE;
                state_r  <= S_OUT;
              end
            endcase
          end
        end

        // Walk the table for the first complete keyframe after the query.
        S_SCAN: begin
          if (entry_complete && entry_after) begin
            p1_r <= ram_rdata.pos;
            f1_r <= ram_rdata.amp;
            if (prev_v_r) begin
              state_r <= S_PREP;
            end else begin
              res_val_r <= ram_rdata.amp;
              state_r   <= S_OUT;
            end
          end else begin
            if (entry_complete) begin
              p0_r     <= ram_rdata.pos;
              f0_r     <= ram_rdata.amp;
              prev_v_r <= 1'b1;
            end
            if (scan_last) begin
              state_r <= S_OUT;
            end else begin
              scan_r <= scan_r + 1'b1;
            end
          end
        end

        // Check the segment and choose the curve.
        S_PREP: begin
          d_r <= seg_d;
          h_r <= seg_h;
          if (seg_h <= 0 || seg_d < 0) begin
            res_val_r <= f0_r;
            state_r   <= S_OUT;
          end else if (mode_r == kfci_pkg::MODE_LIN) begin
            state_r <= S_LMUL;
          end else if (mode_r == kfci_pkg::MODE_CUB) begin
            rem_r   <= 35'(seg_d);
            den_r   <= 35'(seg_h);
            lo_r    <= '0;
            q_r     <= '0;
            cnt_r   <= 5'd16;
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end

        S_LMUL: begin
          prod_r  <= mul_p;
          state_r <= S_LSET;
        end

        S_LSET: begin
          neg_r   <= lin_n[52];
          rem_r   <= {1'b0, lin_abs[51:18]};
          lo_r    <= lin_abs[17:0];
          q_r     <= '0;
          den_r   <= 35'({h_r, 1'b0});
          cnt_r   <= 5'd18;
          state_r <= S_DIV;
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          rem_r <= div_ge ? div_t - den_r : div_t;
          lo_r  <= {lo_r[16:0], 1'b0};
          q_r   <= {q_r[16:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 5'd1) begin
            state_r <= (mode_r == kfci_pkg::MODE_LIN) ? S_LFIN : S_CU2;
          end
        end

        S_LFIN: begin
          res_val_r <= kfci_pkg::sat16(lin_v);
          state_r   <= S_OUT;
        end

        S_CU2: begin
          u2_r    <= q_r[15:0] * q_r[15:0];
          state_r <= S_CU3;
        end

        S_CU3: begin
          u3_r    <= u2_r * q_r[15:0];
          state_r <= S_CS32;
        end

        S_CS32: begin
          s32_r   <= s48_rnd[49:16];
          state_r <= S_CMUL;
        end

        S_CMUL: begin
          prod_r  <= mul_p;
          state_r <= S_CFIN;
        end

        S_CFIN: begin
          res_val_r <= kfci_pkg::sat16(cub_v);
          state_r   <= S_OUT;
        end

        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (out_load) begin
            out_val_r <= res_val_r;
            out_st_r  <= res_st_r;
            state_r   <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the keyframe curve interpolator. A queue of
// clear, append and evaluate transactions is driven with random gaps and
// receiver stalls, while a local model of the keyframe table predicts each
// curve value and status. Results are compared in order, field by field,
// across several effect start and curve mode settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_NOP    = 2'd3;
  localparam logic [1:0] MODE_OFF2 = 2'd2;
  localparam logic [1:0] MODE_OFF3 = 2'd3;
  localparam int         N_ITEMS   = 1950;

  typedef struct {
    logic [1:0]         op;
    logic [23:0]        pos;
    logic               hp;
    logic signed [15:0] amp;
    logic               ha;
    logic [31:0]        qt;
  } curve_op_t;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         status;
  } curve_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [23:0] in_key_position = '0;
  logic in_key_has_position = 1'b0;
  logic signed [15:0] in_key_amplitude = '0;
  logic in_key_has_amplitude = 1'b0;
  logic [31:0] in_query_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_curve_value;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  keyframe_curve_interpolator_top u_top (.*);

  // Model state of the block.
  kfci_pkg::key_entry_t mdl_keys [kfci_pkg::MAX_KEYFRAMES];
  int unsigned mdl_count = 0;
  logic [23:0] mdl_start = '0;
  logic [1:0]  mdl_mode = kfci_pkg::MODE_LIN;
  logic [23:0] mdl_start_next = '0;

  curve_op_t  pend_q [$];
  curve_res_t curve_exp_q [$];
  curve_op_t  cur_op;
  bit         in_took = 0;
  bit         quiet = 0;
  int         tx_gap = 0;
  int         rx_wait = 0;
  int         hold_off = 0;
  int         n_err = 0;
  int         n_gen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic bit key_ok(int i);
    return mdl_keys[i].has_pos && mdl_keys[i].has_amp;
  endfunction

  // Curve value at an absolute query time.
  function automatic logic signed [15:0] curve_at(logic [31:0] qt);
    longint r, t0, t1, d, h, f0, f1, v;
    longint unsigned u, u2, s48, s32;
    int ia, ib;
    bit hit;
    r = longint'(qt) - longint'(mdl_start) * 256;
    hit = 0;
    for (ia = 0; ia < mdl_count; ia++) begin
      if (key_ok(ia) && longint'(mdl_keys[ia].pos) * 256 > r) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return '0;
    hit = 0;
    for (ib = ia - 1; ib >= 0; ib--) begin
      if (key_ok(ib)) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return mdl_keys[ia].amp;
    t0 = longint'(mdl_keys[ib].pos) * 256;
    t1 = longint'(mdl_keys[ia].pos) * 256;
    f0 = mdl_keys[ib].amp;
    f1 = mdl_keys[ia].amp;
    d = r - t0;
    h = t1 - t0;
    if (h <= 0 || d < 0) return f0[15:0];
    if (mdl_mode == kfci_pkg::MODE_LIN) begin
      v = f0 + round_div((f1 - f0) * d, h);
    end else if (mdl_mode == kfci_pkg::MODE_CUB) begin
      u = (d * 65536) / h;
      u2 = u * u;
      s48 = 3 * u2 * 65536 - 2 * u2 * u;
      s32 = (s48 + 32768) >> 16;
      v = f0 + round_div((f1 - f0) * longint'(s32), longint'(1) << 32);
    end else begin
      return '0;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Applies one transaction to the model table and returns its result.
  function automatic curve_res_t apply_op(curve_op_t t);
    curve_res_t res;
    res.value = '0;
    res.status = kfci_pkg::ST_DONE;
    case (t.op)
      kfci_pkg::OP_CLEAR: mdl_count = 0;
      kfci_pkg::OP_APPEND: begin
        if (mdl_count >= kfci_pkg::MAX_KEYFRAMES) begin
          res.status = kfci_pkg::ST_FULL;
        end else begin
          mdl_keys[mdl_count] = '{pos: t.pos, has_pos: t.hp, amp: t.amp, has_amp: t.ha};
          mdl_count++;
        end
      end
      kfci_pkg::OP_EVAL: begin
        res.value = curve_at(t.qt);
        res.status = kfci_pkg::ST_EVAL;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input driver: holds each transaction until accepted, then idles a while.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      in_took = 0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur_op = pend_q.pop_front();
        in_opcode <= cur_op.op;
        in_key_position <= cur_op.pos;
        in_key_has_position <= cur_op.hp;
        in_key_amplitude <= cur_op.amp;
        in_key_has_amplitude <= cur_op.ha;
        in_query_time <= cur_op.qt;
        in_valid <= 1'b1;
        tx_gap = quiet ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per result plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted results.
  always @(posedge clk) begin
    curve_res_t want;
    curve_res_t pred;
    if (rst_n && in_valid && in_ready) begin
      pred = apply_op(cur_op);
      curve_exp_q = {curve_exp_q, pred};
      in_took = 1;
    end
    if (rst_n && out_valid && out_ready) begin
      rx_wait = quiet ? 0 : $urandom_range(0, 6);
      if (curve_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result value=%0d status=%0d",
                                  out_curve_value, out_status);
      end else begin
        want = curve_exp_q.pop_front();
        if (out_curve_value !== want.value || out_status !== want.status) begin
          n_err++;
          if (n_err <= 10)
            $display("result error: value exp %0d got %0d, status exp %0d got %0d",
                     want.value, out_curve_value, want.status, out_status);
        end
      end
    end
  end

  task automatic push_op(logic [1:0] op, logic [23:0] pos, logic hp,
                         logic signed [15:0] amp, logic ha, logic [31:0] qt);
    curve_op_t t;
    t = '{op: op, pos: pos, hp: hp, amp: amp, ha: ha, qt: qt};
    pend_q = {pend_q, t};
    n_gen++;
  endtask

  // Waits until every expected result has arrived and the block is idle.
  task automatic drain();
    do @(posedge clk);
    while (pend_q.size() > 0 || in_valid || curve_exp_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == kfci_pkg::CFG_START) mdl_start = val;
    else mdl_mode = val[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One table load, usually after a clear, then queries mostly around its keyframes.
  task automatic table_burst();
    logic [23:0] p, p0;
    logic [31:0] qt;
    int nk, span;
    nk = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 10);
    p0 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000));
    p = p0;
    if ($urandom_range(0, 5) != 0) push_op(kfci_pkg::OP_CLEAR, 24'($urandom), 1'($urandom),
                                           16'($urandom), 1'($urandom), $urandom);
    for (int i = 0; i < nk; i++) begin
      push_op(kfci_pkg::OP_APPEND, p, $urandom_range(0, 7) != 0, 16'($urandom),
              $urandom_range(0, 7) != 0, $urandom);
      p = ($urandom_range(0, 15) == 0) ? 24'($urandom) : p + 24'($urandom_range(0, 300));
    end
    span = int'(p - p0) + 50;
    for (int i = $urandom_range(2, 12); i > 0; i--) begin
      if ($urandom_range(0, 9) == 0) qt = $urandom;
      else qt = (32'(mdl_start_next) + 32'(p0) + $urandom_range(0, span)) * 256
                + $urandom_range(0, 255) - 32'd128;
      push_op(($urandom_range(0, 19) == 0) ? OP_NOP : kfci_pkg::OP_EVAL, 24'($urandom),
              1'($urandom), 16'($urandom), 1'($urandom), qt);
    end
  endtask

  initial begin
    logic [23:0] starts [8];
    logic [1:0]  modes [8];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, incomplete keys, field extremes, every opcode.
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd1000);
    push_op(kfci_pkg::OP_APPEND, 24'd10, 1'b0, 16'sd5000, 1'b1, '0);
    push_op(kfci_pkg::OP_APPEND, 24'd20, 1'b1, 16'sd7000, 1'b0, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd0);
    push_op(kfci_pkg::OP_APPEND, 24'd0, 1'b1, -16'sd32768, 1'b1, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd0);
    push_op(kfci_pkg::OP_APPEND, 24'd100, 1'b1, 16'sd32767, 1'b1, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd12800);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd12799);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd6400);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd1);
    push_op(kfci_pkg::OP_APPEND, 24'hFFFFFF, 1'b1, -16'sd32768, 1'b1, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'hFFFFFFFF);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'h8000_0000);
    push_op(OP_NOP, 24'hFFFFFF, 1'b1, 16'shFFFF, 1'b1, 32'hFFFFFFFF);
    push_op(kfci_pkg::OP_CLEAR, '0, 1'b0, '0, 1'b0, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd500);
    // Fill the table, then append to the full table.
    for (int i = 0; i < kfci_pkg::MAX_KEYFRAMES + 2; i++)
      push_op(kfci_pkg::OP_APPEND, 24'(i * 7), 1'b1, 16'($urandom), 1'b1, '0);
    push_op(kfci_pkg::OP_EVAL, '0, 1'b0, '0, 1'b0, 32'd100000);
    // Long receiver hold-off while the sender keeps offering items.
    hold_off = 400;
    drain();

    starts = '{24'd0, 24'd0, 24'd1000, 24'hFFFFFF, 24'd37, 24'd500, 24'h7FFFFF, 24'd0};
    modes  = '{kfci_pkg::MODE_CUB, kfci_pkg::MODE_LIN, kfci_pkg::MODE_CUB,
               kfci_pkg::MODE_LIN, MODE_OFF2, MODE_OFF3, kfci_pkg::MODE_CUB,
               kfci_pkg::MODE_LIN};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(kfci_pkg::CFG_START, starts[ph]);
      write_reg(kfci_pkg::CFG_MODE, modes[ph]);
      mdl_start_next = starts[ph];
      quiet = (ph % 3 == 2);
      while (n_gen < 80 + (ph + 1) * (N_ITEMS - 80) / 8) table_burst();
      drain();
    end

    if (n_err == 0) begin
      $display("keyframe_curve_interpolator_top: match");
    end else begin
      $display("keyframe_curve_interpolator_top: mismatch");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #20ms;
    $display("keyframe_curve_interpolator_top: mismatch");
    $finish;
  end

endmodule
